FILE: hdl/lidar_zone_break_obstruction_monitor_macros.svh
// ----------------------------------------------------------------------------
// lidar zone monitor assertion macros
// concurrent assertion helpers clocked on clock, disabled during reset
// ----------------------------------------------------------------------------
`ifndef LIDAR_ZONE_BREAK_OBSTRUCTION_MONITOR_MACROS_SVH
`define LIDAR_ZONE_BREAK_OBSTRUCTION_MONITOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define LZBOM_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LZBOM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LZBOM_ASSERT_IMPLY(name, ante, cons, msg)
`define LZBOM_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

FILE: hdl/lzbom_pkg.sv
// ----------------------------------------------------------------------------
// lzbom_pkg
// shared types and constants of the lidar zone monitor
// ----------------------------------------------------------------------------
`default_nettype none

package lzbom_pkg;

   typedef enum logic [1:0] {
      ALERT_NONE       = 2'd0,
      ALERT_BROKEN     = 2'd1,
      ALERT_OBSTRUCTED = 2'd2,
      ALERT_RECOVERED  = 2'd3
   } alert_code_type;

   localparam logic CMD_STORE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // register select is address bit 2
   localparam logic REG_ENABLE  = 1'b0;
   localparam logic REG_TIMEOUT = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic        ENABLE_RESET  = 1'b1;
   localparam logic [31:0] TIMEOUT_RESET = 32'd60000;

   localparam int ANGLE_W = 9;
   localparam int DIST_W  = 16;
   localparam int ZIDX_W  = 4;
   localparam int ID_W    = 8;
   localparam int TIME_W  = 32;
   localparam int DELTA_W = 17;

   typedef struct packed {
      logic [TIME_W-1:0] start_ms;
      logic              active;
      logic              alerted;
      logic              brk_alerted;
   } zone_rec_type;

endpackage

`default_nettype wire

FILE: hdl/lzbom_if.sv
// ----------------------------------------------------------------------------
// lzbom channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface lzbom_req_if;
   import lzbom_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 cmd;
   logic [ANGLE_W-1:0]   sample_angle;
   logic [DIST_W-1:0]    sample_distance;
   logic [ZIDX_W-1:0]    zone_index;
   logic [ANGLE_W-1:0]   start_angle;
   logic [ANGLE_W-1:0]   end_angle;
   logic [DIST_W-1:0]    baseline_distance;
   logic [DIST_W-1:0]    tolerance;
   logic [ID_W-1:0]      pane_id;
   logic [ID_W-1:0]      zone_tag;
   logic [TIME_W-1:0]    now_ms;

   modport source (
      output valid, cmd, sample_angle, sample_distance, zone_index, start_angle,
             end_angle, baseline_distance, tolerance, pane_id, zone_tag, now_ms,
      input  ready
   );

   modport sink (
      input  valid, cmd, sample_angle, sample_distance, zone_index, start_angle,
             end_angle, baseline_distance, tolerance, pane_id, zone_tag, now_ms,
      output ready
   );
endinterface

interface lzbom_rsp_if;
   import lzbom_pkg::*;

   logic                       valid;
   logic                       ready;
   alert_code_type             alert;
   logic                       has_data;
   logic [DIST_W-1:0]          average_distance;
   logic [ID_W-1:0]            pane_out;
   logic [ID_W-1:0]            zone_out;
   logic [DIST_W-1:0]          baseline_out;
   logic signed [DELTA_W-1:0]  delta;

   modport source (
      output valid, alert, has_data, average_distance, pane_out, zone_out,
             baseline_out, delta,
      input  ready
   );

   modport sink (
      input  valid, alert, has_data, average_distance, pane_out, zone_out,
             baseline_out, delta,
      output ready
   );
endinterface

`default_nettype wire

FILE: hdl/lzbom_div.sv
// ----------------------------------------------------------------------------
// lzbom_div
// restoring divider, one quotient bit per cycle, done pulses on the last bit
// ----------------------------------------------------------------------------
`default_nettype none

module lzbom_div #(
   parameter int DIVIDEND_W = 25,
   parameter int DIVISOR_W  = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic [DIVIDEND_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [DIVIDEND_W-1:0] quot_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dsr_ff;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // shift the next dividend bit into the partial remainder
   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            quot_ff <= dividend;
            rem_ff  <= '0;
            dsr_ff  <= divisor;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[DIVIDEND_W-2:0], fits};
            rem_ff  <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(DIVIDEND_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire

FILE: hdl/lidar_zone_break_obstruction_monitor.sv
// ----------------------------------------------------------------------------
// lidar_zone_break_obstruction_monitor
// per-degree scan store with zone averaging and break/obstruction alerting
// ----------------------------------------------------------------------------
// A store item writes one scan distance. An evaluate item walks the scan
// memory one angle per cycle from start to end angle (wrapping), then divides
// sum by count in a one-bit-per-cycle divider, then updates the zone state
// memory (when it has data and a valid zone index) and loads the result
// register. The divide is skipped when no sample in the zone is nonzero, and
// invalid angles go straight to the result. An evaluate taken while monitoring
// is off is dropped. One item is in work at a time; a finished result waits in
// the output register while the next item is taken, and the next evaluate
// holds before its result until that register is free. After reset the scan
// memory is cleared one entry per cycle, so no item is taken until the clear
// is done; register writes are taken at any time.
`default_nettype none
`include "lidar_zone_break_obstruction_monitor_macros.svh"

module lidar_zone_break_obstruction_monitor #(
   parameter int ZONE_COUNT  = 16,
   parameter int ANGLE_COUNT = 360
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   lzbom_req_if.sink                         req_chan,
   lzbom_rsp_if.source                       rsp_chan,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [lzbom_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [lzbom_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [lzbom_pkg::CSR_DATA_W-1:0] prdata,
   output logic                              pready
);
   import lzbom_pkg::*;

   localparam int AW = $clog2(ANGLE_COUNT);
   localparam int CW = $clog2(ANGLE_COUNT + 1);
   localparam int SW = DIST_W + CW;
   localparam int ZW = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_START,
      S_DIV,
      S_DECIDE
   } state_type;

   // configuration
   logic                  enabled_ff;
   logic [TIME_W-1:0]     timeout_ff;
   logic                  csr_we;

   // control
   state_type             state_ff;
   logic [AW-1:0]         addr_ff;
   logic [AW-1:0]         addr_inc;
   logic                  pend_ff;
   logic [SW-1:0]         sum_ff;
   logic [CW-1:0]         cnt_ff;
   logic [DIST_W-1:0]     avg_ff;
   logic                  rsp_valid_ff;

   // latched evaluate fields
   logic [AW-1:0]         last_addr_ff;
   logic [ZW-1:0]         zone_addr_ff;
   logic                  zone_ok_ff;
   logic [DIST_W-1:0]     base_ff;
   logic [DIST_W-1:0]     tol_ff;
   logic [ID_W-1:0]       pane_ff;
   logic [ID_W-1:0]       tag_ff;
   logic [TIME_W-1:0]     now_ff;

   // result register
   alert_code_type        alert_ff;
   logic                  has_data_ff;
   logic [DIST_W-1:0]     avg_out_ff;
   logic [ID_W-1:0]       pane_out_ff;
   logic [ID_W-1:0]       zone_out_ff;
   logic [DIST_W-1:0]     base_out_ff;
   logic signed [DELTA_W-1:0] delta_ff;

   // scan memory
   logic [DIST_W-1:0]     scan_mem [ANGLE_COUNT];
   logic [DIST_W-1:0]     rd_data_ff;
   logic                  scan_we;
   logic [AW-1:0]         scan_waddr;
   logic [DIST_W-1:0]     scan_wdata;

   // zone memory
   zone_rec_type          zone_mem [ZONE_COUNT];
   zone_rec_type          zrd_ff;
   logic [ZONE_COUNT-1:0] zvalid_ff;
   logic                  zvld_rd_ff;
   logic                  zone_we;

   // divider
   logic                  div_start;
   logic                  div_done;
   logic [SW-1:0]         div_quot;

   // input decode
   logic                  req_acc;
   logic [31:0]           s_angle_ext;
   logic [31:0]           first_ext;
   logic [31:0]           last_ext;
   logic [31:0]           zidx_ext;
   logic                  sample_ok;
   logic                  angles_ok;

   // decide
   zone_rec_type          zrec;
   zone_rec_type          zone_rec_in;
   alert_code_type        alert_in;
   logic [DIST_W:0]       upper_in;
   logic [TIME_W-1:0]     elapsed_in;
   logic signed [DELTA_W-1:0] delta_in;
   logic                  has_data;
   logic                  out_free;
   logic                  commit;

   // ------------------------------------------------------------------ csr
   assign csr_we = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= ENABLE_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (paddr[2])
            REG_ENABLE:  enabled_ff <= pwdata[0];
            REG_TIMEOUT: timeout_ff <= pwdata;
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_ENABLE:  prdata = {{(CSR_DATA_W-1){1'b0}}, enabled_ff};
         REG_TIMEOUT: prdata = timeout_ff;
         default:     prdata = '0;
      endcase
   end

   // ---------------------------------------------------------- input decode
   assign req_acc     = req_chan.valid && req_chan.ready;
   assign s_angle_ext = 32'(req_chan.sample_angle);
   assign first_ext   = 32'(req_chan.start_angle);
   assign last_ext    = 32'(req_chan.end_angle);
   assign zidx_ext    = 32'(req_chan.zone_index);
   assign sample_ok   = s_angle_ext < 32'(ANGLE_COUNT);
   assign angles_ok   = (first_ext < 32'(ANGLE_COUNT)) && (last_ext < 32'(ANGLE_COUNT));

   assign addr_inc = (addr_ff == AW'(ANGLE_COUNT - 1)) ? '0 : addr_ff + 1'b1;

   // ------------------------------------------------------------ scan memory
   assign scan_we    = (state_ff == S_CLEAR) ||
                       (req_acc && req_chan.cmd == CMD_STORE && sample_ok);
   assign scan_waddr = (state_ff == S_CLEAR) ? addr_ff : s_angle_ext[AW-1:0];
   assign scan_wdata = (state_ff == S_CLEAR) ? '0 : req_chan.sample_distance;

   always_ff @(posedge clock) begin
      if (scan_we) begin
         scan_mem[scan_waddr] <= scan_wdata;
      end
      rd_data_ff <= scan_mem[addr_ff];
   end

   // ------------------------------------------------------------ zone memory
   always_ff @(posedge clock) begin
      if (zone_we) begin
         zone_mem[zone_addr_ff] <= zone_rec_in;
      end
      zrd_ff     <= zone_mem[zone_addr_ff];
      zvld_rd_ff <= zvalid_ff[zone_addr_ff];
   end

   // an entry never written reads as the reset record
   always_ff @(posedge clock) begin
      if (reset) begin
         zvalid_ff <= '0;
      end else if (zone_we) begin
         zvalid_ff[zone_addr_ff] <= 1'b1;
      end
   end

   // --------------------------------------------------------------- divider
   assign div_start = (state_ff == S_START) && (cnt_ff != '0);

   lzbom_div #(
      .DIVIDEND_W (SW),
      .DIVISOR_W  (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------- decide
   assign has_data = cnt_ff != '0;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign commit   = (state_ff == S_DECIDE) && out_free;
   assign zone_we  = commit && has_data && zone_ok_ff;

   always_comb begin
      zrec        = zvld_rd_ff ? zrd_ff : '0;
      zone_rec_in = zrec;
      alert_in    = ALERT_NONE;
      upper_in    = {1'b0, base_ff} + {1'b0, tol_ff};
      elapsed_in  = now_ff - zrec.start_ms;

      if ({1'b0, avg_ff} > upper_in) begin
         if (!zrec.brk_alerted) begin
            alert_in = ALERT_BROKEN;
         end
         zone_rec_in.brk_alerted = 1'b1;
         zone_rec_in.active      = 1'b0;
         zone_rec_in.start_ms    = '0;
         zone_rec_in.alerted     = 1'b0;
      end else if ((tol_ff < base_ff) && (avg_ff < base_ff - tol_ff)) begin
         // the evaluate that opens an obstruction never alerts
         if (!zrec.active) begin
            zone_rec_in.active   = 1'b1;
            zone_rec_in.start_ms = now_ff;
            zone_rec_in.alerted  = 1'b0;
         end else if (!zrec.alerted && elapsed_in >= timeout_ff) begin
            alert_in            = ALERT_OBSTRUCTED;
            zone_rec_in.alerted = 1'b1;
         end
      end else begin
         if (zrec.active) begin
            if (zrec.alerted) begin
               alert_in = ALERT_RECOVERED;
            end
            zone_rec_in.active   = 1'b0;
            zone_rec_in.start_ms = '0;
            zone_rec_in.alerted  = 1'b0;
         end
         zone_rec_in.brk_alerted = 1'b0;
      end

      if (!(has_data && zone_ok_ff)) begin
         alert_in = ALERT_NONE;
      end

      delta_in = has_data ? (DELTA_W'({1'b0, avg_ff}) - DELTA_W'({1'b0, base_ff})) : '0;
   end

   // ---------------------------------------------------------- control fsm
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_SCAN);

         // one memory read behind the address walk
         if (pend_ff && rd_data_ff != '0) begin
            sum_ff <= sum_ff + SW'(rd_data_ff);
            cnt_ff <= cnt_ff + 1'b1;
         end

         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_CLEAR: begin
               if (addr_ff == AW'(ANGLE_COUNT - 1)) begin
                  addr_ff  <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  addr_ff <= addr_inc;
               end
            end
            S_IDLE: begin
               if (req_acc && req_chan.cmd == CMD_EVAL && enabled_ff) begin
                  zone_addr_ff <= zidx_ext[ZW-1:0];
                  zone_ok_ff   <= zidx_ext < 32'(ZONE_COUNT);
                  last_addr_ff <= last_ext[AW-1:0];
                  base_ff      <= req_chan.baseline_distance;
                  tol_ff       <= req_chan.tolerance;
                  pane_ff      <= req_chan.pane_id;
                  tag_ff       <= req_chan.zone_tag;
                  now_ff       <= req_chan.now_ms;
                  sum_ff       <= '0;
                  cnt_ff       <= '0;
                  avg_ff       <= '0;
                  if (angles_ok) begin
                     addr_ff  <= first_ext[AW-1:0];
                     state_ff <= S_SCAN;
                  end else begin
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_SCAN: begin
               if (addr_ff == last_addr_ff) begin
                  state_ff <= S_DRAIN;
               end else begin
                  addr_ff <= addr_inc;
               end
            end
            S_DRAIN: begin
               state_ff <= S_START;
            end
            S_START: begin
               if (cnt_ff == '0) begin
                  avg_ff   <= '0;
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (div_done) begin
                  avg_ff   <= div_quot[DIST_W-1:0];
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  alert_ff     <= alert_in;
                  has_data_ff  <= has_data;
                  avg_out_ff   <= avg_ff;
                  pane_out_ff  <= pane_ff;
                  zone_out_ff  <= tag_ff;
                  base_out_ff  <= base_ff;
                  delta_ff     <= delta_in;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- ports
   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.alert            = alert_ff;
   assign rsp_chan.has_data         = has_data_ff;
   assign rsp_chan.average_distance = avg_out_ff;
   assign rsp_chan.pane_out         = pane_out_ff;
   assign rsp_chan.zone_out         = zone_out_ff;
   assign rsp_chan.baseline_out     = base_out_ff;
   assign rsp_chan.delta            = delta_ff;

   // ------------------------------------------------------------ assertions
   `LZBOM_ASSERT_IMPLY(a_div_done_in_div, div_done, state_ff == S_DIV,
      "divider finished outside the divide state")
   `LZBOM_ASSERT_IMPLY(a_cnt_bound, pend_ff, 32'(cnt_ff) < 32'(ANGLE_COUNT),
      "sample count reached the angle count before the last read")
   `LZBOM_ASSERT_NEXT(a_zone_valid, zone_we, zvalid_ff[zone_addr_ff],
      "zone entry not marked valid after write-back")
   `LZBOM_ASSERT_IMPLY(a_rsp_from_decide, $rose(rsp_valid_ff), $past(state_ff) == S_DECIDE,
      "result raised outside the decide state")

endmodule

`default_nettype wire

FILE: verif/tb_lidar_zone_break_obstruction_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_zone_break_obstruction_monitor
// Drives scan stores and zone evaluates through the request channel. A local
// model of the scan store and the per-zone alert flags predicts each zone
// report, and every report from the block is checked in order against it.
// Covers reset state, directed alert sequences, timeout extremes, monitoring off,
// random zone episodes and a long response stall.
// ----------------------------------------------------------------------------

module tb_lidar_zone_break_obstruction_monitor;
   import lzbom_pkg::*;

   localparam int ZONES         = 16;
   localparam int ANGLES        = 360;
   localparam int SETTLE_CYCLES = 450;
   localparam int HOLD_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 3_000_000;

   typedef struct {
      logic               cmd;
      logic [ANGLE_W-1:0] sample_angle;
      logic [DIST_W-1:0]  sample_distance;
      logic [ZIDX_W-1:0]  zone_index;
      logic [ANGLE_W-1:0] start_angle;
      logic [ANGLE_W-1:0] end_angle;
      logic [DIST_W-1:0]  baseline_distance;
      logic [DIST_W-1:0]  tolerance;
      logic [ID_W-1:0]    pane_id;
      logic [ID_W-1:0]    zone_tag;
      logic [TIME_W-1:0]  now_ms;
   } scan_cmd_type;

   typedef struct {
      alert_code_type            alert;
      logic                      has_data;
      logic [DIST_W-1:0]         average_distance;
      logic [ID_W-1:0]           pane_out;
      logic [ID_W-1:0]           zone_out;
      logic [DIST_W-1:0]         baseline_out;
      logic signed [DELTA_W-1:0] delta;
   } zone_report_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   lzbom_req_if req_if ();
   lzbom_rsp_if rsp_if ();

   lidar_zone_break_obstruction_monitor #(
      .ZONE_COUNT  (ZONES),
      .ANGLE_COUNT (ANGLES)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // local copy of the block's state and registers
   logic [DIST_W-1:0] scan_mm [ANGLES] = '{default: '0};
   logic [TIME_W-1:0] obs_since [ZONES] = '{default: '0};
   bit obs_active [ZONES];
   bit obs_alerted [ZONES];
   bit brk_alerted [ZONES];
   logic              cfg_enable     = ENABLE_RESET;
   logic [TIME_W-1:0] cfg_timeout_ms = TIMEOUT_RESET;

   zone_report_type zone_reports_due [$];

   // zone geometry kept across episodes so transitions between states happen
   int unsigned zg_first [ZONES];
   int unsigned zg_len [ZONES];
   int unsigned zg_base [ZONES];
   int unsigned zg_tol [ZONES];
   bit          zg_set [ZONES];
   logic [TIME_W-1:0] clock_ms = '0;

   int unsigned req_idle_pct = 28;
   int unsigned rsp_idle_pct = 28;
   bit          rsp_hold_request = 1'b0;
   int unsigned items_sent = 0;
   int unsigned stores_sent = 0;
   int unsigned evals_sent = 0;
   int unsigned reports_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned alerts_seen [4] = '{default: 0};
   int unsigned cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("lidar_zone_break_obstruction_monitor: mismatch");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void clear_obstruction_timer(input int unsigned zi);
      obs_active[zi]  = 1'b0;
      obs_since[zi]   = '0;
      obs_alerted[zi] = 1'b0;
   endfunction

   function automatic bit predict_zone_report(input scan_cmd_type c,
                                              output zone_report_type r);
      logic [31:0] sum;
      logic [31:0] cnt;
      logic [31:0] avg;
      logic [31:0] angle;
      logic [31:0] upper;
      logic [31:0] diff;
      logic [TIME_W-1:0] elapsed;
      int unsigned zi;
      bit at_end;
      r.alert            = ALERT_NONE;
      r.has_data         = 1'b0;
      r.average_distance = '0;
      r.pane_out         = c.pane_id;
      r.zone_out         = c.zone_tag;
      r.baseline_out     = c.baseline_distance;
      r.delta            = '0;
      if (c.cmd == CMD_STORE) begin
         if (c.sample_angle < ANGLES)
            scan_mm[c.sample_angle] = c.sample_distance;
         return 1'b0;
      end
      if (!cfg_enable)
         return 1'b0;
      sum = '0;
      cnt = '0;
      if (c.start_angle < ANGLES && c.end_angle < ANGLES) begin
         angle  = 32'(c.start_angle);
         at_end = 1'b0;
         while (!at_end) begin
            if (scan_mm[angle] != '0) begin
               sum = sum + 32'(scan_mm[angle]);
               cnt = cnt + 1;
            end
            if (angle == 32'(c.end_angle))
               at_end = 1'b1;
            else
               angle = (angle == ANGLES - 1) ? 32'd0 : angle + 1;
         end
      end
      if (cnt == 0)
         return 1'b1;
      avg = sum / cnt;
      diff = avg - 32'(c.baseline_distance);
      r.has_data         = 1'b1;
      r.average_distance = avg[DIST_W-1:0];
      r.delta            = diff[DELTA_W-1:0];
      zi = c.zone_index;
      upper = 32'(c.baseline_distance) + 32'(c.tolerance);
      if (avg == 0 || avg > upper) begin
         if (!brk_alerted[zi]) begin
            r.alert = ALERT_BROKEN;
            brk_alerted[zi] = 1'b1;
         end
         clear_obstruction_timer(zi);
      end else if (c.tolerance < c.baseline_distance &&
                   avg < 32'(c.baseline_distance) - 32'(c.tolerance)) begin
         elapsed = c.now_ms - obs_since[zi];
         if (!obs_active[zi]) begin
            // the evaluate that starts the timer never alerts
            obs_active[zi]  = 1'b1;
            obs_since[zi]   = c.now_ms;
            obs_alerted[zi] = 1'b0;
         end else if (!obs_alerted[zi] && elapsed >= cfg_timeout_ms) begin
            r.alert = ALERT_OBSTRUCTED;
            obs_alerted[zi] = 1'b1;
         end
      end else begin
         if (obs_active[zi]) begin
            if (obs_alerted[zi])
               r.alert = ALERT_RECOVERED;
            clear_obstruction_timer(zi);
         end
         brk_alerted[zi] = 1'b0;
      end
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // item construction
   // ------------------------------------------------------------------------
   function automatic scan_cmd_type random_scan_cmd();
      scan_cmd_type c;
      c.cmd               = 1'($urandom_range(0, 1));
      c.sample_angle      = ANGLE_W'($urandom_range(0, 511));
      c.sample_distance   = DIST_W'($urandom_range(0, 65535));
      c.zone_index        = ZIDX_W'($urandom_range(0, 15));
      c.start_angle       = ANGLE_W'($urandom_range(0, 511));
      c.end_angle         = ANGLE_W'($urandom_range(0, 511));
      c.baseline_distance = DIST_W'($urandom_range(0, 65535));
      c.tolerance         = DIST_W'($urandom_range(0, 65535));
      c.pane_id           = ID_W'($urandom_range(0, 255));
      c.zone_tag          = ID_W'($urandom_range(0, 255));
      c.now_ms            = $urandom;
      return c;
   endfunction

   function automatic scan_cmd_type make_store(input int unsigned angle, input int unsigned mm);
      scan_cmd_type c;
      c = random_scan_cmd();
      c.cmd             = CMD_STORE;
      c.sample_angle    = ANGLE_W'(angle);
      c.sample_distance = DIST_W'(mm);
      return c;
   endfunction

   function automatic scan_cmd_type make_eval(input int unsigned zi, input int unsigned first,
                                              input int unsigned last, input int unsigned base,
                                              input int unsigned tol,
                                              input logic [TIME_W-1:0] now);
      scan_cmd_type c;
      c = random_scan_cmd();
      c.cmd               = CMD_EVAL;
      c.zone_index        = ZIDX_W'(zi);
      c.start_angle       = ANGLE_W'(first);
      c.end_angle         = ANGLE_W'(last);
      c.baseline_distance = DIST_W'(base);
      c.tolerance         = DIST_W'(tol);
      c.now_ms            = now;
      return c;
   endfunction

   // distance for one sample: 0 normal band, 1 beyond far limit, 2 short, else anything; one in ten is 0
   function automatic int unsigned zone_distance(input int unsigned mode,
                                                 input int unsigned base,
                                                 input int unsigned tol);
      int unsigned lo;
      int unsigned hi;
      if ($urandom_range(0, 9) == 0)
         return 0;
      case (mode)
         0: begin
            lo = (base > tol) ? base - tol : 1;
            hi = (base + tol > 65535) ? 65535 : base + tol;
         end
         1: begin
            lo = (base + tol + 1 > 65535) ? 65535 : base + tol + 1;
            hi = 65535;
         end
         2: begin
            lo = 1;
            hi = (base > tol + 1) ? base - tol - 1 : 1;
         end
         default: begin
            lo = 1;
            hi = 65535;
         end
      endcase
      if (lo == 0)
         lo = 1;
      return $urandom_range(lo, hi);
   endfunction

   function automatic logic [TIME_W-1:0] time_step();
      if (cfg_timeout_ms < 32'h4000_0000)
         return $urandom_range(0, cfg_timeout_ms + cfg_timeout_ms / 2 + 3);
      return $urandom;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   task automatic send_item(input scan_cmd_type c);
      zone_report_type r;
      req_if.valid             <= 1'b1;
      req_if.cmd               <= c.cmd;
      req_if.sample_angle      <= c.sample_angle;
      req_if.sample_distance   <= c.sample_distance;
      req_if.zone_index        <= c.zone_index;
      req_if.start_angle       <= c.start_angle;
      req_if.end_angle         <= c.end_angle;
      req_if.baseline_distance <= c.baseline_distance;
      req_if.tolerance         <= c.tolerance;
      req_if.pane_id           <= c.pane_id;
      req_if.zone_tag          <= c.zone_tag;
      req_if.now_ms            <= c.now_ms;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      items_sent++;
      if (c.cmd == CMD_STORE)
         stores_sent++;
      else
         evals_sent++;
      if (predict_zone_report(c, r))
         zone_reports_due.push_back(r);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < req_idle_pct);
      end
   endtask

   task automatic wait_results_done();
      req_if.valid <= 1'b0;
      while (zone_reports_due.size() != 0)
         @(posedge clock);
   endtask

   // stores and ignored evaluates leave no report, so give the block time to finish
   task automatic wait_block_idle();
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (reg_sel == REG_ENABLE)
         cfg_enable = value[0];
      else
         cfg_timeout_ms = value;
      @(posedge clock);
   endtask

   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // report checking
   // ------------------------------------------------------------------------
   function automatic void log_mismatch(input string why, input zone_report_type want,
                                        input zone_report_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] %s: exp alert=%0d data=%0d avg=%0d pane=%0d zone=%0d base=%0d dl=%0d",
                  $realtime, why, want.alert, want.has_data, want.average_distance,
                  want.pane_out, want.zone_out, want.baseline_out, want.delta);
         $display("   got alert=%0d data=%0d avg=%0d pane=%0d zone=%0d base=%0d dl=%0d",
                  got.alert, got.has_data, got.average_distance, got.pane_out,
                  got.zone_out, got.baseline_out, got.delta);
      end
   endfunction

   always @(posedge clock) begin
      zone_report_type got;
      zone_report_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.alert            = rsp_if.alert;
         got.has_data         = rsp_if.has_data;
         got.average_distance = rsp_if.average_distance;
         got.pane_out         = rsp_if.pane_out;
         got.zone_out         = rsp_if.zone_out;
         got.baseline_out     = rsp_if.baseline_out;
         got.delta            = rsp_if.delta;
         reports_checked++;
         if (!$isunknown(got.alert))
            alerts_seen[got.alert]++;
         if (zone_reports_due.size() == 0) begin
            log_mismatch("report with no evaluate pending", got, got);
         end else begin
            want = zone_reports_due.pop_front();
            if (got.alert !== want.alert || got.has_data !== want.has_data ||
                got.average_distance !== want.average_distance ||
                got.pane_out !== want.pane_out || got.zone_out !== want.zone_out ||
                got.baseline_out !== want.baseline_out || got.delta !== want.delta)
               log_mismatch("zone report mismatch", want, got);
         end
      end
   end

   // ------------------------------------------------------------------------
   // random traffic
   // ------------------------------------------------------------------------
   function automatic void pick_zone_geometry(input int unsigned zi);
      zg_first[zi] = $urandom_range(0, ANGLES - 1);
      zg_len[zi]   = ($urandom_range(0, 4) == 0) ? $urandom_range(9, ANGLES)
                                                 : $urandom_range(1, 8);
      zg_base[zi]  = $urandom_range(100, 40000);
      // now and then a tolerance at or above the baseline, which rules out obstruction
      zg_tol[zi]   = ($urandom_range(0, 7) == 0) ? $urandom_range(zg_base[zi], 65535)
                                                 : $urandom_range(0, zg_base[zi] / 3);
      zg_set[zi]   = 1'b1;
   endfunction

   // write up to eight of a zone's angles with one kind of return, then evaluate it a few times
   task automatic run_zone_episode(input int unsigned zi);
      int unsigned mode;
      int unsigned n_writes;
      int unsigned n_evals;
      int unsigned pos;
      int unsigned last;
      if (!zg_set[zi] || $urandom_range(0, 5) == 0)
         pick_zone_geometry(zi);
      mode = $urandom_range(0, 3);
      n_writes = (zg_len[zi] <= 8) ? zg_len[zi] : 8;
      for (int i = 0; i < n_writes; i++) begin
         pos = (zg_len[zi] <= 8) ? i : $urandom_range(0, zg_len[zi] - 1);
         send_item(make_store((zg_first[zi] + pos) % ANGLES,
                              zone_distance(mode, zg_base[zi], zg_tol[zi])));
      end
      last = (zg_first[zi] + zg_len[zi] - 1) % ANGLES;
      n_evals = $urandom_range(1, 3);
      for (int i = 0; i < n_evals; i++) begin
         clock_ms = clock_ms + time_step();
         send_item(make_eval(zi, zg_first[zi], last, zg_base[zi], zg_tol[zi], clock_ms));
      end
   endtask

   task automatic run_traffic(input int unsigned n_items);
      int unsigned stop_at;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(0, 99) < 15)
            send_item(random_scan_cmd());
         else
            run_zone_episode($urandom_range(0, ZONES - 1));
      end
   endtask

   task automatic run_phase(input logic [TIME_W-1:0] timeout, input int unsigned idle_pct,
                            input int unsigned n_items);
      wait_block_idle();
      csr_write(REG_TIMEOUT, timeout);
      req_idle_pct = idle_pct;
      rsp_idle_pct = idle_pct;
      run_traffic(n_items);
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_state();
      // scan store comes out of reset cleared
      send_item(make_eval(0, 0, ANGLES - 1, 1000, 10, 0));
      send_item(make_store(0, 65535));
      send_item(make_store(ANGLES - 1, 1));
      // out of range angles are dropped
      send_item(make_store(ANGLES, 777));
      send_item(make_store(511, 5));
      // wrap from the last angle to the first
      send_item(make_eval(1, ANGLES - 1, 0, 32768, 0, 0));
      // start one past end covers the whole circle
      send_item(make_eval(2, 1, 0, 0, 65535, 0));
      // invalid start or end gives no data
      send_item(make_eval(3, ANGLES, 10, 500, 5, 0));
      send_item(make_eval(3, 10, 511, 500, 5, 0));
   endtask

   task automatic test_alert_sequence();
      // default timeout: obstruction alert only once the full timeout has passed
      send_item(make_store(100, 500));
      send_item(make_eval(15, 100, 100, 1000, 100, 1000));
      send_item(make_eval(15, 100, 100, 1000, 100, 60999));
      send_item(make_eval(15, 100, 100, 1000, 100, 61000));
      send_item(make_store(100, 1000));
      send_item(make_eval(15, 100, 100, 1000, 100, 62000));
      // break alert fires once
      send_item(make_store(100, 65535));
      send_item(make_eval(15, 100, 100, 1000, 100, 63000));
      send_item(make_eval(15, 100, 100, 1000, 100, 64000));
      // tolerance above baseline: short return counts as normal
      send_item(make_store(100, 50));
      send_item(make_eval(15, 100, 100, 100, 200, 65000));
   endtask

   task automatic test_timeout_extremes();
      wait_block_idle();
      csr_write(REG_TIMEOUT, '0);
      // zero timeout still needs a second evaluate
      send_item(make_eval(5, 100, 100, 1000, 100, 7));
      send_item(make_eval(5, 100, 100, 1000, 100, 7));
      wait_block_idle();
      csr_write(REG_TIMEOUT, '1);
      // elapsed time wraps modulo 2^32
      send_item(make_eval(6, 100, 100, 1000, 100, 5));
      send_item(make_eval(6, 100, 100, 1000, 100, 3));
      send_item(make_eval(6, 100, 100, 1000, 100, 4));
   endtask

   task automatic test_monitoring_disabled();
      wait_block_idle();
      csr_write(REG_ENABLE, 1'b0);
      csr_write(REG_TIMEOUT, '0);
      send_item(make_eval(7, 100, 100, 1000, 100, 10));
      send_item(make_store(100, 2000));
      wait_block_idle();
      csr_write(REG_ENABLE, 1'b1);
      // if the ignored evaluate had armed the timer this one would alert
      send_item(make_eval(7, 100, 100, 3000, 100, 20));
      send_item(make_eval(7, 100, 100, 3000, 100, 20));
      // random stretch with monitoring off
      wait_block_idle();
      csr_write(REG_ENABLE, 1'b0);
      run_traffic(60);
      wait_block_idle();
      csr_write(REG_ENABLE, 1'b1);
   endtask

   task automatic test_random_traffic();
      run_phase('0, 28, 350);
      run_phase($urandom_range(1, 2000), 0, 300);
      run_phase($urandom_range(20000, 200000), 28, 300);
      run_phase(TIMEOUT_RESET, 28, 200);
      run_phase('1, 28, 150);
      run_phase($urandom, 28, 150);
   endtask

   task automatic test_result_backpressure();
      wait_block_idle();
      csr_write(REG_TIMEOUT, $urandom_range(0, 50));
      req_idle_pct = 0;
      rsp_idle_pct = 28;
      rsp_hold_request = 1'b1;
      run_traffic(80);
      // sender holds until everything has drained, then resumes
      wait_results_done();
      req_idle_pct = 28;
      run_traffic(40);
   endtask

   initial begin
      reset   <= 1'b1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= '0;
      pwdata  <= '0;
      req_if.valid             <= 1'b0;
      req_if.cmd               <= CMD_STORE;
      req_if.sample_angle      <= '0;
      req_if.sample_distance   <= '0;
      req_if.zone_index        <= '0;
      req_if.start_angle       <= '0;
      req_if.end_angle         <= '0;
      req_if.baseline_distance <= '0;
      req_if.tolerance         <= '0;
      req_if.pane_id           <= '0;
      req_if.zone_tag          <= '0;
      req_if.now_ms            <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_alert_sequence();
      test_timeout_extremes();
      test_monitoring_disabled();
      test_random_traffic();
      test_result_backpressure();
      wait_block_idle();

      $display("covered %0d items (%0d scan stores, %0d zone evaluates) in %0d cycles",
               items_sent, stores_sent, evals_sent, cycle_count);
      $display("checked %0d zone reports: %0d broken, %0d obstructed, %0d restored alerts",
               reports_checked, alerts_seen[ALERT_BROKEN], alerts_seen[ALERT_OBSTRUCTED],
               alerts_seen[ALERT_RECOVERED]);
      if (mismatch_count == 0 && zone_reports_due.size() == 0) begin
         $display("lidar_zone_break_obstruction_monitor: match");
      end else begin
         $display("%0d mismatches, %0d reports never arrived", mismatch_count,
                  zone_reports_due.size());
         $display("lidar_zone_break_obstruction_monitor: mismatch");
      end
      $finish;
   end

endmodule

FILE: lidar_zone_break_obstruction_monitor.f
+incdir+hdl
hdl/lzbom_pkg.sv
hdl/lzbom_if.sv
hdl/lzbom_div.sv
hdl/lidar_zone_break_obstruction_monitor.sv
verif/tb_lidar_zone_break_obstruction_monitor.sv
